>>> hw/rtl/urde_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urde_pkg: shared types and constants of the UART register datagram engine
// Request and result codes, the reply phase encoding, configuration register
// indexes and the byte-wise CRC-8 step.
// ----------------------------------------------------------------------------
package urde_pkg;

  // Kind of an incoming word.
  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_RX    = 2'd2,
    REQ_TICK  = 2'd3
  } req_type_e;

  // Kind of an outgoing word.
  typedef enum logic [1:0] {
    KIND_TX   = 2'd0,
    KIND_OK   = 2'd1,
    KIND_FAIL = 2'd2
  } out_kind_e;

  // Reply phase, one-hot.
  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_HUNT = 3'b010,
    PH_DATA = 3'b100
  } phase_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_NODE    = 2'd0,
    CFG_SYNC    = 2'd1,
    CFG_TIMEOUT = 2'd2,
    CFG_MAXATT  = 2'd3
  } cfg_idx_e;

  localparam logic [7:0] CrcPoly    = 8'h07;
  localparam logic [7:0] HdrMid     = 8'hFF;
  localparam logic [3:0] WriteBytes = 4'd8;
  localparam logic [3:0] ReadBytes  = 4'd4;
  localparam logic [2:0] DataBytes  = 3'd5;

  // One byte through the CRC-8, least significant bit first.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                           input logic [7:0] data);
    logic [7:0] crc;
    logic       fb;
    crc = crc_in;
    for (int k = 0; k < 8; k++) begin
      fb  = crc[7] ^ data[k];
      crc = {crc[6:0], 1'b0} ^ (fb ? CrcPoly : 8'h00);
    end
    return crc;
  endfunction

endpackage

>>> hw/rtl/uart_register_datagram_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_register_datagram_engine: master side of a register-access UART link
// Builds write and read datagrams with CRC-8, hunts replies for the header,
// checks the reply CRC and retries failed reads.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Words
//  s_axis    in         one request, received byte or millisecond tick
//  m_axis    out        one byte to transmit, or one read status
//  cfg       in         register write: node, sync, timeout, max attempts
//
// An accepted word is held in the input register and is then processed into
// the result buffer, which drains one word per cycle while m_axis_tready is
// high. A write request loads eight words into the result buffer, a read
// frame four, a status one. The next word is taken while results still
// drain, and is processed in the cycle the final result of the previous word
// is taken.
// rst_ni clears all control state asynchronously and loads the register
// defaults. m_axis_tready low simply holds the buffer and backs up s_axis.
module uart_register_datagram_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input words.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // reg_addr[6:0], write_data[38:7], rx_byte[46:39]
  input  logic [1:0]  s_axis_tuser,  // req_type[1:0]
  // Result words.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // tx_byte[7:0], read_data[39:8]
  output logic [1:0]  m_axis_tuser,  // out_kind[1:0]
  output logic        m_axis_tlast,
  // Configuration writes.
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  // Configuration registers.
  logic [7:0]  node_q, sync_q;
  logic [15:0] timeout_q;
  logic [3:0]  maxatt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_q    <= 8'd0;
      sync_q    <= 8'd5;
      timeout_q <= 16'd20;
      maxatt_q  <= 4'd3;
    end else if (cfg_we_i) begin
      case (urde_pkg::cfg_idx_e'(cfg_idx_i))
        urde_pkg::CFG_NODE:    node_q    <= cfg_data_i[7:0];
        urde_pkg::CFG_SYNC:    sync_q    <= cfg_data_i[7:0];
        urde_pkg::CFG_TIMEOUT: timeout_q <= cfg_data_i;
        urde_pkg::CFG_MAXATT:  maxatt_q  <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Input register.
  logic                   in_valid_q;
  urde_pkg::req_type_e    in_type_q;
  logic [6:0]             in_addr_q;
  logic [31:0]            in_wdata_q;
  logic [7:0]             in_rx_q;
  logic                   s_fire, proc_fire, m_fire, buf_free;

  // Result buffer: up to seven queued bytes plus a trailing CRC, or a status.
  logic [3:0]             count_q, count_d;
  urde_pkg::out_kind_e    kind_q, kind_d;
  logic [55:0]            bytes_q, bytes_d;
  logic [31:0]            data_q, data_d;
  logic [7:0]             crc_tx_q, crc_tx_d;

  assign m_fire        = m_axis_tvalid && m_axis_tready;
  assign buf_free      = (count_q == 4'd0) || ((count_q == 4'd1) && m_fire);
  assign proc_fire     = in_valid_q && buf_free;
  assign s_axis_tready = !in_valid_q || proc_fire;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_type_q  <= urde_pkg::req_type_e'(s_axis_tuser);
      in_addr_q  <= s_axis_tdata[6:0];
      in_wdata_q <= s_axis_tdata[38:7];
      in_rx_q    <= s_axis_tdata[46:39];
    end
  end

  // Reply tracking state.
  urde_pkg::phase_e phase_q, phase_d;
  logic [23:0]      hdr_q, hdr_d;
  logic [31:0]      dat_q, dat_d;
  logic [2:0]       cnt_q, cnt_d;
  logic [15:0]      tick_q, tick_d;
  logic [3:0]       att_q, att_d;
  logic [6:0]       pend_q, pend_d;
  logic [7:0]       crc_rx_q, crc_rx_d;

  // Processing results.
  logic [3:0]          res_cnt;
  urde_pkg::out_kind_e res_kind;
  logic [55:0]         res_bytes;
  logic [31:0]         res_data;
  logic                do_fail, do_send;
  logic [3:0]          att_inc;
  logic [2:0]          cnt_inc;
  logic [23:0]         win;

  assign att_inc = att_q + 4'd1;
  assign cnt_inc = cnt_q + 3'd1;
  assign win     = {hdr_q[15:0], in_rx_q};

  always_comb begin
    phase_d   = phase_q;
    hdr_d     = hdr_q;
    dat_d     = dat_q;
    cnt_d     = cnt_q;
    tick_d    = tick_q;
    att_d     = att_q;
    pend_d    = pend_q;
    crc_rx_d  = crc_rx_q;
    res_cnt   = 4'd0;
    res_kind  = urde_pkg::KIND_TX;
    res_bytes = '0;
    res_data  = '0;
    do_fail   = 1'b0;
    do_send   = 1'b0;

    case (in_type_q)
      urde_pkg::REQ_WRITE: begin
        if (phase_q == urde_pkg::PH_IDLE) begin
          // Bytes go out lowest first; the CRC is appended while draining.
          res_cnt   = urde_pkg::WriteBytes;
          res_bytes = {in_wdata_q[7:0], in_wdata_q[15:8], in_wdata_q[23:16],
                       in_wdata_q[31:24], 1'b1, in_addr_q, node_q, sync_q};
        end
      end
      urde_pkg::REQ_READ: begin
        if (phase_q == urde_pkg::PH_IDLE) begin
          pend_d = in_addr_q;
          att_d  = 4'd0;
          if (maxatt_q == 4'd0) begin
            res_cnt  = 4'd1;
            res_kind = urde_pkg::KIND_FAIL;
          end else begin
            do_send = 1'b1;
          end
        end
      end
      urde_pkg::REQ_RX: begin
        if (phase_q == urde_pkg::PH_HUNT) begin
          hdr_d = win;
          if (win == {sync_q, urde_pkg::HdrMid, 1'b0, pend_q}) begin
            phase_d  = urde_pkg::PH_DATA;
            dat_d    = '0;
            cnt_d    = 3'd0;
            tick_d   = timeout_q;
            crc_rx_d = urde_pkg::crc8_byte(urde_pkg::crc8_byte(
                         urde_pkg::crc8_byte(8'h00, win[23:16]), win[15:8]), win[7:0]);
          end
        end else if (phase_q == urde_pkg::PH_DATA) begin
          cnt_d = cnt_inc;
          if (cnt_inc >= urde_pkg::DataBytes) begin
            // The fifth data byte is the CRC of the seven bytes before it.
            if ((crc_rx_q == in_rx_q) && (crc_rx_q != 8'h00)) begin
              phase_d  = urde_pkg::PH_IDLE;
              res_cnt  = 4'd1;
              res_kind = urde_pkg::KIND_OK;
              res_data = dat_q;
            end else begin
              do_fail = 1'b1;
            end
          end else begin
            dat_d    = {dat_q[23:0], in_rx_q};
            crc_rx_d = urde_pkg::crc8_byte(crc_rx_q, in_rx_q);
          end
        end
      end
      urde_pkg::REQ_TICK: begin
        if (phase_q != urde_pkg::PH_IDLE) begin
          if (tick_q <= 16'd1) begin
            tick_d  = 16'd0;
            do_fail = 1'b1;
          end else begin
            tick_d = tick_q - 16'd1;
          end
        end
      end
      default: ;
    endcase

    if (do_fail) begin
      att_d = att_inc;
      if ((att_inc >= maxatt_q) || (att_inc == 4'd0)) begin
        phase_d  = urde_pkg::PH_IDLE;
        res_cnt  = 4'd1;
        res_kind = urde_pkg::KIND_FAIL;
      end else begin
        do_send = 1'b1;
      end
    end

    if (do_send) begin
      phase_d   = urde_pkg::PH_HUNT;
      hdr_d     = '0;
      dat_d     = '0;
      cnt_d     = 3'd0;
      tick_d    = timeout_q;
      res_cnt   = urde_pkg::ReadBytes;
      res_kind  = urde_pkg::KIND_TX;
      res_bytes = {32'h0, 1'b0, pend_d, node_q, sync_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= urde_pkg::PH_IDLE;
      hdr_q    <= '0;
      dat_q    <= '0;
      cnt_q    <= 3'd0;
      tick_q   <= 16'd0;
      att_q    <= 4'd0;
      pend_q   <= 7'd0;
      crc_rx_q <= 8'd0;
    end else if (proc_fire) begin
      phase_q  <= phase_d;
      hdr_q    <= hdr_d;
      dat_q    <= dat_d;
      cnt_q    <= cnt_d;
      tick_q   <= tick_d;
      att_q    <= att_d;
      pend_q   <= pend_d;
      crc_rx_q <= crc_rx_d;
    end
  end

  // Result buffer load and drain. The transmit CRC runs over bytes as they
  // leave and stands in for the final byte of a frame.
  always_comb begin
    count_d  = count_q;
    kind_d   = kind_q;
    bytes_d  = bytes_q;
    data_d   = data_q;
    crc_tx_d = crc_tx_q;
    if (proc_fire) begin
      count_d  = res_cnt;
      kind_d   = res_kind;
      bytes_d  = res_bytes;
      data_d   = res_data;
      crc_tx_d = 8'h00;
    end else if (m_fire) begin
      count_d  = count_q - 4'd1;
      bytes_d  = {8'h00, bytes_q[55:8]};
      crc_tx_d = urde_pkg::crc8_byte(crc_tx_q, bytes_q[7:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 4'd0;
      kind_q  <= urde_pkg::KIND_TX;
    end else begin
      count_q <= count_d;
      kind_q  <= kind_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q  <= bytes_d;
    data_q   <= data_d;
    crc_tx_q <= crc_tx_d;
  end

  logic [7:0] tx_byte;
  assign tx_byte = (kind_q != urde_pkg::KIND_TX) ? 8'h00 :
                   (count_q == 4'd1) ? crc_tx_q : bytes_q[7:0];

  assign m_axis_tvalid = (count_q != 4'd0);
  assign m_axis_tlast  = (count_q == 4'd1);
  assign m_axis_tuser  = kind_q;
  assign m_axis_tdata  = {(kind_q == urde_pkg::KIND_TX) ? 32'h0 : data_q, tx_byte};

  // A frame never holds more than eight bytes.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= urde_pkg::WriteBytes)
    else $error("result buffer count out of range");

  // A status is always a single, final word.
  a_status_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != 4'd0) && (kind_q != urde_pkg::KIND_TX) |-> (count_q == 4'd1))
    else $error("status word not alone in buffer");

  // Collecting data only starts on a matched header.
  a_hdr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(phase_q == urde_pkg::PH_DATA) |->
      (hdr_q == {sync_q, urde_pkg::HdrMid, 1'b0, pend_q}))
    else $error("data phase entered without header match");

  // The data byte count ends the reply on its fifth byte.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == urde_pkg::PH_DATA) |-> (cnt_q < urde_pkg::DataBytes))
    else $error("reply byte count overran");

endmodule
